/* rtl/bm_pkg.sv */
// Shared types and constants for the batch median block.
package bm_pkg;

  localparam int unsigned MAX_VALUES_DEF = 256;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    batch_end;
  } bm_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] median_value;
    logic                    overflowed;
  } bm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_INS,
    ST_MRD0,
    ST_MRD1,
    ST_MRD2,
    ST_OUT
  } bm_state_t;

endpackage

/* rtl/batch_median.sv */
// Batch median top level: insertion sort in memory, median readout on batch end.
// Insertion: each stored entry greater than a new word is shifted up one place through the
//   store's separate read and write ports, then the word is written into the gap.
// A closing word adds the middle-entry reads (both middle entries, averaged, for an even count), then the result.
// Throughput: one word per insertion pass; the next word is taken when the pass ends.
// Reset: rst_n synchronous active low clears count, overflow flag, FSM and output valid.
module batch_median #(
  parameter int unsigned MAX_VALUES = bm_pkg::MAX_VALUES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bm_pkg::bm_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bm_pkg::bm_out_t out_data
);
  import bm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VALUES);
  localparam int unsigned CW = $clog2(MAX_VALUES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VALUES);

  bm_state_t state_r, state_nxt;

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic                    last_r, last_nxt;
  logic                    ovf_r, ovf_nxt;
  logic signed [VAL_W-1:0] a_r, a_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;
  bm_out_t                 out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [VAL_W-1:0]        mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [VAL_W-1:0]        mem_rdata;

  logic                    acc;
  logic                    out_free;
  logic [AW-1:0]           half;
  logic signed [VAL_W:0]   sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign half      = AW'(cnt_r >> 1);
  assign sum       = {a_r[VAL_W-1], a_r} + {mem_rdata[VAL_W-1], mem_rdata};
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  bm_store #(.DEPTH(MAX_VALUES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (cnt_r == CNT_MAX || cnt_r == '0) begin
            state_nxt = in_data.batch_end ? ST_MRD0 : ST_IDLE;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if ($signed(mem_rdata) > v_r) begin
          if (pos_r == AW'(1)) begin
            state_nxt = ST_INS;
          end
        end else begin
          state_nxt = last_r ? ST_MRD0 : ST_IDLE;
        end
      end
      ST_INS:  state_nxt = last_r ? ST_MRD0 : ST_IDLE;
      ST_MRD0: state_nxt = ST_MRD1;
      ST_MRD1: state_nxt = cnt_r[0] ? ST_OUT : ST_MRD2;
      ST_MRD2: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    a_nxt         = a_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = v_r;
    mem_raddr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          v_nxt    = in_data.sample_value;
          last_nxt = in_data.batch_end;
          if (cnt_r == CNT_MAX) begin
            ovf_nxt = 1'b1;
          end else if (cnt_r == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = in_data.sample_value;
            cnt_nxt   = CW'(1);
          end else begin
            mem_raddr = AW'(cnt_r - CW'(1));
            pos_nxt   = AW'(cnt_r);
          end
        end
      end
      ST_SHIFT: begin
        mem_we = 1'b1;
        if ($signed(mem_rdata) > v_r) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - AW'(1);
          mem_raddr = pos_r - AW'(2);
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        cnt_nxt   = cnt_r + CW'(1);
      end
      ST_MRD0: begin
        mem_raddr = cnt_r[0] ? half : half - AW'(1);
      end
      ST_MRD1: begin
        a_nxt     = mem_rdata;
        res_nxt   = mem_rdata;
        mem_raddr = half;
      end
      ST_MRD2: begin
        res_nxt = sum[VAL_W:1];
      end
      ST_OUT: begin
        if (out_free) begin
          out_nxt.median_value = res_r;
          out_nxt.overflowed   = ovf_r;
          out_valid_nxt        = 1'b1;
          cnt_nxt              = '0;
          ovf_nxt              = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    v_r    <= v_nxt;
    last_r <= last_nxt;
    a_r    <= a_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("value count above capacity");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> pos_r != '0)
    else $error("shift pass at entry zero");

  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (cnt_r == '0 && !ovf_r && out_valid_r))
    else $error("batch state not cleared after result");

  a_no_ovf_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && acc && cnt_r != CNT_MAX) |=> ovf_r == $past(ovf_r))
    else $error("overflow flag set while store had room");

endmodule

/* rtl/bm_store.sv */
// Sorted value store: one write port, one read port, registered read data.
module bm_store #(
  parameter int unsigned DEPTH = bm_pkg::MAX_VALUES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bm_pkg::VAL_W-1:0]    wdata,
  input  logic [AW-1:0]               raddr,
  output logic [bm_pkg::VAL_W-1:0]    rdata
);
  import bm_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
